FILE: sv/iets_pkg.sv
// ----------------------------------------------------------------------------
// iets_pkg
// shared codes, constants and types for the i2c eeprom transaction sequencer
// ----------------------------------------------------------------------------
package iets_pkg;

    // item operation codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;

    // bus engine commands
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_SEND  = 3'd2;
    localparam logic [2:0] CMD_RECV  = 3'd3;
    localparam logic [2:0] CMD_STOP  = 3'd4;

    // masked bus status codes
    localparam logic [7:0] ST_MASK     = 8'hF8;
    localparam logic [7:0] ST_START    = 8'h08;
    localparam logic [7:0] ST_RESTART  = 8'h10;
    localparam logic [7:0] ST_SLA_W    = 8'h18;
    localparam logic [7:0] ST_SLA_R    = 8'h40;
    localparam logic [7:0] ST_DATA_ACK = 8'h28;
    localparam logic [7:0] ST_RX_NACK  = 8'h58;

    // configuration
    localparam int         APB_ADDR_W     = 2;
    localparam int         APB_DATA_W     = 32;
    localparam int         DEV_ADDR_W     = 7;
    localparam logic [6:0] DEV_ADDR_RESET = 7'd80;
    localparam logic [APB_ADDR_W-1:0] REG_DEVICE_ADDRESS = '0;

    // one result item
    typedef struct packed {
        logic [2:0] bus_command;
        logic [7:0] send_byte;
        logic       done_res;
        logic       success;
        logic [7:0] read_byte;
        logic       rejected;
    } iets_result_t;

endpackage

FILE: sv/iets_regs.sv
// ----------------------------------------------------------------------------
// iets_regs
// apb configuration register file holding the seven-bit device address
// ----------------------------------------------------------------------------
module iets_regs
    import iets_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [DEV_ADDR_W-1:0] dev_addr
);

    logic [DEV_ADDR_W-1:0] dev_addr_reg;
    logic [DEV_ADDR_W-1:0] dev_addr_next;
    logic                  wr_en;
    logic                  hit;

    // single register at byte address 0
    assign hit   = (paddr == REG_DEVICE_ADDRESS);
    assign wr_en = psel && penable && pwrite && hit;

    always_comb
    begin
        dev_addr_next = dev_addr_reg;
        if (wr_en)
        begin
            dev_addr_next = pwdata[DEV_ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= DEV_ADDR_RESET;
        end
        else
        begin
            dev_addr_reg <= dev_addr_next;
        end
    end

    assign pready   = 1'b1;
    assign prdata   = {{(APB_DATA_W-DEV_ADDR_W){1'b0}}, dev_addr_reg};
    assign dev_addr = dev_addr_reg;

endmodule

FILE: sv/iets_core.sv
// ----------------------------------------------------------------------------
// iets_core
// transaction fsm and result register, one item per cycle unless output stalls
// ----------------------------------------------------------------------------
module iets_core
    import iets_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic [1:0]            operation,
    input  logic [15:0]           mem_address,
    input  logic [7:0]            write_byte,
    input  logic [7:0]            bus_status,
    input  logic [7:0]            received_byte,
    input  logic [DEV_ADDR_W-1:0] dev_addr,
    output logic                  res_valid,
    input  logic                  res_ready,
    output iets_result_t          res
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_SLA_W,
        PH_ADDR_HI,
        PH_ADDR_LO,
        PH_DATA,
        PH_RESTART,
        PH_SLA_R,
        PH_RECV
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [15:0]  target_reg, target_next;
    logic [7:0]   pending_reg, pending_next;
    logic         read_mode_reg, read_mode_next;
    logic         res_valid_reg, res_valid_next;
    iets_result_t res_reg, res_next;
    logic         advance;
    logic [7:0]   expected;
    logic [7:0]   status_masked;

    // result register takes a new item when empty or being drained
    assign advance    = item_valid && (!res_valid_reg || res_ready);
    assign item_ready = advance;

    assign status_masked = bus_status & ST_MASK;

    always_comb
    begin
        unique case (phase_reg) inside
            PH_START:   expected = ST_START;
            PH_SLA_W:   expected = ST_SLA_W;
            PH_ADDR_HI,
            PH_ADDR_LO,
            PH_DATA:    expected = ST_DATA_ACK;
            PH_RESTART: expected = ST_RESTART;
            PH_SLA_R:   expected = ST_SLA_R;
            PH_RECV:    expected = ST_RX_NACK;
            default:    expected = ST_MASK;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        target_next    = target_reg;
        pending_next   = pending_reg;
        read_mode_next = read_mode_reg;
        res_next       = '0;

        case (operation) inside
            OP_WRITE, OP_READ:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    res_next.rejected = 1'b1;
                end
                else
                begin
                    target_next          = mem_address;
                    pending_next         = write_byte;
                    read_mode_next       = operation[0];
                    phase_next           = PH_START;
                    res_next.bus_command = CMD_START;
                end
            end
            OP_STATUS:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    res_next.rejected = 1'b1;
                end
                else if (status_masked != expected)
                begin
                    // unexpected status aborts the transaction
                    res_next.bus_command = CMD_STOP;
                    res_next.done_res    = 1'b1;
                    phase_next           = PH_IDLE;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_START:
                        begin
                            res_next.bus_command = CMD_SEND;
                            res_next.send_byte   = {dev_addr, 1'b0};
                            phase_next           = PH_SLA_W;
                        end
                        PH_SLA_W:
                        begin
                            res_next.bus_command = CMD_SEND;
                            res_next.send_byte   = target_reg[15:8];
                            phase_next           = PH_ADDR_HI;
                        end
                        PH_ADDR_HI:
                        begin
                            res_next.bus_command = CMD_SEND;
                            res_next.send_byte   = target_reg[7:0];
                            phase_next           = PH_ADDR_LO;
                        end
                        PH_ADDR_LO:
                        begin
                            if (read_mode_reg)
                            begin
                                res_next.bus_command = CMD_START;
                                phase_next           = PH_RESTART;
                            end
                            else
                            begin
                                res_next.bus_command = CMD_SEND;
                                res_next.send_byte   = pending_reg;
                                phase_next           = PH_DATA;
                            end
                        end
                        PH_DATA:
                        begin
                            res_next.bus_command = CMD_STOP;
                            res_next.done_res    = 1'b1;
                            res_next.success     = 1'b1;
                            phase_next           = PH_IDLE;
                        end
                        PH_RESTART:
                        begin
                            res_next.bus_command = CMD_SEND;
                            res_next.send_byte   = {dev_addr, 1'b1};
                            phase_next           = PH_SLA_R;
                        end
                        PH_SLA_R:
                        begin
                            res_next.bus_command = CMD_RECV;
                            phase_next           = PH_RECV;
                        end
                        default:
                        begin
                            res_next.bus_command = CMD_STOP;
                            res_next.done_res    = 1'b1;
                            res_next.success     = 1'b1;
                            res_next.read_byte   = received_byte;
                            phase_next           = PH_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            target_reg    <= '0;
            pending_reg   <= '0;
            read_mode_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                phase_reg     <= phase_next;
                target_reg    <= target_next;
                pending_reg   <= pending_next;
                read_mode_reg <= read_mode_next;
                res_reg       <= res_next;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: sv/i2c_eeprom_transaction_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_transaction_sequencer
// sequences single-byte eeprom writes and random reads over an i2c bus engine
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | operation, mem_address, write_byte,
//           |                       | bus_status, received_byte
//  out      | out_valid / out_ready | bus_command, send_byte, done_res,
//           |                       | success, read_byte, rejected
//  config   | apb psel / penable    | device_address at byte address 0
//
//  one transfer per cycle on each side while neither side stalls; an input
//  passes the input register, then the result register offers its result
//  throughput is set by the single state update per cycle in iets_core
//  reset clears the phase, core and valid registers; no clearing pass
//  a stalled output holds its result while one more input waits in the
//  input register, then in_ready drops
//
module i2c_eeprom_transaction_sequencer
    import iets_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            operation,
    input  logic [15:0]           mem_address,
    input  logic [7:0]            write_byte,
    input  logic [7:0]            bus_status,
    input  logic [7:0]            received_byte,
    // output channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            bus_command,
    output logic [7:0]            send_byte,
    output logic                  done_res,
    output logic                  success,
    output logic [7:0]            read_byte,
    output logic                  rejected,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // input register
    logic                  item_valid_reg, item_valid_next;
    logic [1:0]            op_reg;
    logic [15:0]           addr_reg;
    logic [7:0]            wbyte_reg;
    logic [7:0]            status_reg;
    logic [7:0]            rbyte_reg;
    logic                  item_ready;
    logic                  in_xfer;
    logic [DEV_ADDR_W-1:0] dev_addr;
    iets_result_t          res;

    // input register refills whenever its item moves on to the core
    assign in_ready = !item_valid_reg || item_ready;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_xfer)
        begin
            item_valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg     <= operation;
            addr_reg   <= mem_address;
            wbyte_reg  <= write_byte;
            status_reg <= bus_status;
            rbyte_reg  <= received_byte;
        end
    end

    iets_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .dev_addr (dev_addr)
    );

    // sequencer step and result register
    iets_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid_reg),
        .item_ready    (item_ready),
        .operation     (op_reg),
        .mem_address   (addr_reg),
        .write_byte    (wbyte_reg),
        .bus_status    (status_reg),
        .received_byte (rbyte_reg),
        .dev_addr      (dev_addr),
        .res_valid     (out_valid),
        .res_ready     (out_ready),
        .res           (res)
    );

    assign bus_command = res.bus_command;
    assign send_byte   = res.send_byte;
    assign done_res    = res.done_res;
    assign success     = res.success;
    assign read_byte   = res.read_byte;
    assign rejected    = res.rejected;

endmodule

FILE: sv/iets_checker.sv
// ----------------------------------------------------------------------------
// iets_checker
// port-level checks for the i2c eeprom transaction sequencer
// ----------------------------------------------------------------------------
module iets_checker
    import iets_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] bus_command,
    input logic [7:0] send_byte,
    input logic       done_res,
    input logic       success,
    input logic [7:0] read_byte,
    input logic       rejected
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bus_command)
            && $stable(send_byte) && $stable(read_byte))
        else $error("stalled result changed");

    // only a finished transaction reports success or a read byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> !success && (read_byte == 8'd0))
        else $error("success or read data outside transaction end");

    // an end of transaction always issues stop
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> (bus_command == CMD_STOP) && !rejected)
        else $error("transaction end without stop");

    // a rejected item issues no bus command and no data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> (bus_command == CMD_NONE) && (send_byte == 8'd0))
        else $error("rejected item drove the bus");

    // send data only travels with a send command
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (bus_command != CMD_SEND) |-> (send_byte == 8'd0))
        else $error("send byte without send command");

endmodule

bind i2c_eeprom_transaction_sequencer iets_checker u_iets_checker (.*);

FILE: tb/i2c_eeprom_transaction_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_eeprom_transaction_sequencer_tb
// self-checking bench for the eeprom byte write / random read sequencer
//
// drives requests and bus status reports over the valid/ready input channel,
// keeps its own model of the transaction phase and the device address, and
// compares every result transfer field by field against the oldest predicted
// bus action; the device address register is swept over the apb port
// ----------------------------------------------------------------------------
module i2c_eeprom_transaction_sequencer_tb;
    import iets_pkg::*;

    // operation code the block treats as a no-op
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // generous run limit, well above the slowest legal run
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int PRESSURE_HOLD = 80;

    // transaction phase as tracked by the bench
    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_START,
        SEQ_DEV_W,
        SEQ_ADDR_HI,
        SEQ_ADDR_LO,
        SEQ_DATA,
        SEQ_RESTART,
        SEQ_DEV_R,
        SEQ_RECV
    } seq_phase_t;

    // one input transfer
    typedef struct {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  wbyte;
        logic [7:0]  status;
        logic [7:0]  rbyte;
    } seq_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            operation;
    logic [15:0]           mem_address;
    logic [7:0]            write_byte;
    logic [7:0]            bus_status;
    logic [7:0]            received_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [2:0]            bus_command;
    logic [7:0]            send_byte;
    logic                  done_res;
    logic                  success;
    logic [7:0]            read_byte;
    logic                  rejected;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // bench copy of the sequencer state
    seq_phase_t      seq_phase;
    logic [15:0]     seq_target;
    logic [7:0]      seq_data;
    logic            seq_is_read;
    logic [6:0]      seq_dev_addr;

    // predicted bus actions, oldest first
    iets_result_t    expected_actions[$];

    int  check_failures = 0;
    int  payload_items = 0;
    int  cycle_count = 0;
    int  hold_off_cycles = 0;
    bit  sender_idle = 1'b1;
    bit  receiver_idle = 1'b1;

    i2c_eeprom_transaction_sequencer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .mem_address   (mem_address),
        .write_byte    (write_byte),
        .bus_status    (bus_status),
        .received_byte (received_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .bus_command   (bus_command),
        .send_byte     (send_byte),
        .done_res      (done_res),
        .success       (success),
        .read_byte     (read_byte),
        .rejected      (rejected),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // masked status code the bus engine must report in each phase
    function automatic logic [7:0] status_for_phase(input seq_phase_t ph);
        case (ph)
            SEQ_START:   return ST_START;
            SEQ_DEV_W:   return ST_SLA_W;
            SEQ_ADDR_HI: return ST_DATA_ACK;
            SEQ_ADDR_LO: return ST_DATA_ACK;
            SEQ_DATA:    return ST_DATA_ACK;
            SEQ_RESTART: return ST_RESTART;
            SEQ_DEV_R:   return ST_SLA_R;
            default:     return ST_RX_NACK;
        endcase
    endfunction

    // advances the bench state by one accepted transfer and returns the
    // bus action the block must produce for it
    function automatic iets_result_t sequence_step(input seq_item_t it);
        iets_result_t act;
        logic [7:0]   masked;
        act = '0;
        masked = it.status & ST_MASK;
        if (it.op == OP_WRITE || it.op == OP_READ)
        begin
            if (seq_phase != SEQ_IDLE)
                act.rejected = 1'b1;
            else
            begin
                seq_target = it.addr;
                seq_data = it.wbyte;
                seq_is_read = (it.op == OP_READ);
                seq_phase = SEQ_START;
                act.bus_command = CMD_START;
            end
        end
        else if (it.op == OP_STATUS)
        begin
            if (seq_phase == SEQ_IDLE)
                act.rejected = 1'b1;
            else if (masked != status_for_phase(seq_phase))
            begin
                // unexpected status aborts with stop
                act.bus_command = CMD_STOP;
                act.done_res = 1'b1;
                seq_phase = SEQ_IDLE;
            end
            else
            begin
                case (seq_phase)
                    SEQ_START:
                    begin
                        act.bus_command = CMD_SEND;
                        act.send_byte = {seq_dev_addr, 1'b0};
                        seq_phase = SEQ_DEV_W;
                    end
                    SEQ_DEV_W:
                    begin
                        act.bus_command = CMD_SEND;
                        act.send_byte = seq_target[15:8];
                        seq_phase = SEQ_ADDR_HI;
                    end
                    SEQ_ADDR_HI:
                    begin
                        act.bus_command = CMD_SEND;
                        act.send_byte = seq_target[7:0];
                        seq_phase = SEQ_ADDR_LO;
                    end
                    SEQ_ADDR_LO:
                    begin
                        if (seq_is_read)
                        begin
                            act.bus_command = CMD_START;
                            seq_phase = SEQ_RESTART;
                        end
                        else
                        begin
                            act.bus_command = CMD_SEND;
                            act.send_byte = seq_data;
                            seq_phase = SEQ_DATA;
                        end
                    end
                    SEQ_DATA:
                    begin
                        act.bus_command = CMD_STOP;
                        act.done_res = 1'b1;
                        act.success = 1'b1;
                        seq_phase = SEQ_IDLE;
                    end
                    SEQ_RESTART:
                    begin
                        act.bus_command = CMD_SEND;
                        act.send_byte = {seq_dev_addr, 1'b1};
                        seq_phase = SEQ_DEV_R;
                    end
                    SEQ_DEV_R:
                    begin
                        act.bus_command = CMD_RECV;
                        seq_phase = SEQ_RECV;
                    end
                    default:
                    begin
                        act.bus_command = CMD_STOP;
                        act.done_res = 1'b1;
                        act.success = 1'b1;
                        act.read_byte = it.rbyte;
                        seq_phase = SEQ_IDLE;
                    end
                endcase
            end
        end
        return act;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s expected 0x%0h actual 0x%0h", field, want, got);
            check_failures++;
        end
    endtask

    // every result transfer is matched against the oldest prediction
    always @(posedge clk)
    begin : result_checker
        iets_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_actions.size() == 0)
            begin
                $error("result transfer with nothing expected, bus_command %0d",
                       bus_command);
                check_failures++;
            end
            else
            begin
                want = expected_actions.pop_front();
                compare_field("bus_command", 8'(want.bus_command), 8'(bus_command));
                compare_field("send_byte", want.send_byte, send_byte);
                compare_field("done_res", 8'(want.done_res), 8'(done_res));
                compare_field("success", 8'(want.success), 8'(success));
                compare_field("read_byte", want.read_byte, read_byte);
                compare_field("rejected", 8'(want.rejected), 8'(rejected));
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : out_ready_driver
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                // long stall so the block fills up and drops in_ready
                out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            stall = receiver_idle ? $urandom_range(0, 8) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            // wait for one result transfer, or for a hold-off request
            do
                @(posedge clk);
            while (!out_valid && hold_off_cycles == 0);
        end
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    function automatic seq_item_t random_item();
        seq_item_t it;
        it.op = 2'($urandom_range(0, 3));
        it.addr = 16'($urandom_range(0, 16'hFFFF));
        it.wbyte = 8'($urandom_range(0, 8'hFF));
        it.status = 8'($urandom_range(0, 8'hFF));
        it.rbyte = 8'($urandom_range(0, 8'hFF));
        return it;
    endfunction

    // offers one item, after a random gap if sender_idle is set, and records
    // the predicted action at the edge where the transfer happens
    task automatic send_item(input seq_item_t it);
        int gap;
        gap = sender_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= it.op;
        mem_address <= it.addr;
        write_byte <= it.wbyte;
        bus_status <= it.status;
        received_byte <= it.rbyte;
        do
            @(posedge clk);
        while (!in_ready);
        expected_actions.push_back(sequence_step(it));
        if (it.op != OP_UNUSED)
            payload_items++;
    endtask

    // stops offering and waits for every outstanding result
    task automatic wait_until_quiet();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_actions.size() != 0);
    endtask

    // one request followed by the status reports that walk it to the end;
    // break_at picks the report that carries a wrong code, busy_at the step
    // before which a second request is pushed in (-1 for neither)
    task automatic run_transaction(input logic [1:0] req_op, input logic [15:0] addr,
                                   input logic [7:0] data, input logic [7:0] rx_byte,
                                   input int break_at, input int busy_at);
        seq_item_t  it;
        logic [7:0] code;
        int         step;
        it = random_item();
        it.op = req_op;
        it.addr = addr;
        it.wbyte = data;
        send_item(it);
        step = 0;
        while (seq_phase != SEQ_IDLE)
        begin
            if (step == busy_at)
            begin
                it = random_item();
                it.op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
                send_item(it);
            end
            code = status_for_phase(seq_phase);
            it = random_item();
            it.op = OP_STATUS;
            it.rbyte = rx_byte;
            if (step == break_at)
            begin
                do
                    it.status = 8'($urandom_range(0, 8'hFF));
                while ((it.status & ST_MASK) == code);
            end
            else
                // low three bits are don't-care and must be masked off
                it.status = code | 8'($urandom_range(0, 7));
            send_item(it);
            step++;
        end
    endtask

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == REG_DEVICE_ADDRESS)
            seq_dev_addr = data[DEV_ADDR_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_device_address();
        logic [APB_DATA_W-1:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= REG_DEVICE_ADDRESS;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== APB_DATA_W'(seq_dev_addr))
        begin
            $error("device_address expected 0x%0h actual 0x%0h", seq_dev_addr, got);
            check_failures++;
        end
    endtask

    task automatic set_device_address(input logic [6:0] value);
        wait_until_quiet();
        apb_write(REG_DEVICE_ADDRESS, APB_DATA_W'(value));
        check_device_address();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_register_reset();
        check_device_address();
    endtask

    // address and data extremes, a successful write and read, a request
    // while busy, an abort on the first report and on the receive report,
    // a report while idle and the unused operation code
    task automatic test_directed_transactions();
        seq_item_t it;
        run_transaction(OP_WRITE, 16'hFFFF, 8'h00, 8'h00, -1, -1);
        run_transaction(OP_READ, 16'h0000, 8'hFF, 8'hFF, -1, -1);
        run_transaction(OP_WRITE, 16'h00FF, 8'hFF, 8'h00, -1, 2);
        run_transaction(OP_READ, 16'hFF00, 8'h00, 8'hA5, 0, -1);
        run_transaction(OP_READ, 16'h5AA5, 8'h3C, 8'h00, 6, -1);
        it = random_item();
        it.op = OP_STATUS;
        send_item(it);
        it = random_item();
        it.op = OP_UNUSED;
        send_item(it);
    endtask

    // device address extremes, a random and the reset value, each with a read and a write
    task automatic test_device_address_sweep();
        logic [6:0] values[4];
        values = '{7'd0, 7'd127, 7'($urandom_range(1, 126)), DEV_ADDR_RESET};
        foreach (values[i])
        begin
            set_device_address(values[i]);
            run_transaction(OP_READ, 16'($urandom), 8'($urandom), 8'($urandom), -1, -1);
            run_transaction(OP_WRITE, 16'($urandom), 8'($urandom), 8'($urandom), -1, -1);
        end
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        wait_until_quiet();
        sender_idle = 1'b0;
        hold_off_cycles = PRESSURE_HOLD;
        repeat (3)
            run_transaction(OP_WRITE, 16'($urandom), 8'($urandom), 8'($urandom), -1, -1);
        sender_idle = 1'b1;
    endtask

    task automatic test_random_traffic();
        seq_item_t it;
        int        pick;
        int        target;
        int        next_toggle;
        int        next_reconfig;
        target = payload_items + RANDOM_ITEMS;
        next_toggle = payload_items + 100;
        next_reconfig = payload_items + 250;
        while (payload_items < target)
        begin
            if (payload_items >= next_toggle)
            begin
                // idling on both sides switched in stretches
                sender_idle = ($urandom_range(0, 2) != 0);
                receiver_idle = ($urandom_range(0, 2) != 0);
                next_toggle += 100;
            end
            if (payload_items >= next_reconfig)
            begin
                case ($urandom_range(0, 3))
                    0:       set_device_address(7'd0);
                    1:       set_device_address(7'd127);
                    default: set_device_address(7'($urandom));
                endcase
                next_reconfig += 250;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                // well-formed transaction, sometimes aborted or poked
                run_transaction($urandom_range(0, 1) ? OP_READ : OP_WRITE,
                                16'($urandom), 8'($urandom), 8'($urandom),
                                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : -1,
                                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : -1);
            else if (pick < 80)
            begin
                it = random_item();
                it.op = OP_STATUS;
                send_item(it);
            end
            else if (pick < 90)
            begin
                // request followed by junk reports
                it = random_item();
                it.op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
                send_item(it);
                repeat ($urandom_range(1, 3))
                begin
                    it = random_item();
                    it.op = OP_STATUS;
                    send_item(it);
                end
            end
            else
                send_item(random_item());
        end
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_WRITE;
        mem_address = '0;
        write_byte = '0;
        bus_status = '0;
        received_byte = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        seq_phase = SEQ_IDLE;
        seq_target = '0;
        seq_data = '0;
        seq_is_read = 1'b0;
        seq_dev_addr = DEV_ADDR_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_directed_transactions();
        test_device_address_sweep();
        test_backpressure();
        test_random_traffic();

        // let anything stray come out before the verdict
        wait_until_quiet();
        repeat (10) @(posedge clk);
        if (check_failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
sv/iets_pkg.sv
sv/iets_regs.sv
sv/iets_core.sv
sv/i2c_eeprom_transaction_sequencer.sv
sv/iets_checker.sv
tb/i2c_eeprom_transaction_sequencer_tb.sv
